// ===== rtl/atp_pkg.sv =====
`timescale 1ns / 1ps
package atp_pkg;
    localparam int NUM_REGS = 6;
    localparam int SAMPLE_WIDTH = 16;
    localparam logic [2:0] REG_GAIN_X   = 3'd0;
    localparam logic [2:0] REG_GAIN_Y   = 3'd1;
    localparam logic [2:0] REG_GAIN_Z   = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z = 3'd5;

    localparam logic signed [15:0] CX_FROM_Y = -16'sd516;
    localparam logic signed [15:0] CX_FROM_Z = -16'sd104;
    localparam logic signed [15:0] CY_FROM_X = -16'sd306;
    localparam logic signed [15:0] CY_FROM_Z = -16'sd19;
    localparam logic signed [15:0] CZ_FROM_X = -16'sd1;
    localparam logic signed [15:0] CZ_FROM_Y = -16'sd74;

    localparam logic signed [15:0] ANGLE_MAX = 16'sd23040;
    localparam logic signed [15:0] ANGLE_QTR = 16'sd11520;
    localparam logic signed [31:0] HALF_TURN_Q16 = 32'sd11796480;

    typedef struct packed {
        logic signed [15:0] gain_x;
        logic signed [15:0] gain_y;
        logic signed [15:0] gain_z;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
    } cal_regs_t;

    function automatic logic [15:0] fir_coef(input int k);
        case (k)
            0: fir_coef = 16'd6554;
            1: fir_coef = 16'd9830;
            2: fir_coef = 16'd32768;
            3: fir_coef = 16'd9830;
            4: fir_coef = 16'd6554;
            default: fir_coef = 16'd0;
        endcase
    endfunction

    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 22'd2949120;
            5'd1: atan_q16 = 22'd1740967;
            5'd2: atan_q16 = 22'd919879;
            5'd3: atan_q16 = 22'd466945;
            5'd4: atan_q16 = 22'd234379;
            5'd5: atan_q16 = 22'd117304;
            5'd6: atan_q16 = 22'd58666;
            5'd7: atan_q16 = 22'd29335;
            5'd8: atan_q16 = 22'd14668;
            5'd9: atan_q16 = 22'd7334;
            5'd10: atan_q16 = 22'd3667;
            5'd11: atan_q16 = 22'd1833;
            5'd12: atan_q16 = 22'd917;
            5'd13: atan_q16 = 22'd458;
            5'd14: atan_q16 = 22'd229;
            5'd15: atan_q16 = 22'd115;
            5'd16: atan_q16 = 22'd57;
            5'd17: atan_q16 = 22'd29;
            5'd18: atan_q16 = 22'd14;
            5'd19: atan_q16 = 22'd7;
            5'd20: atan_q16 = 22'd4;
            5'd21: atan_q16 = 22'd2;
            5'd22: atan_q16 = 22'd1;
            default: atan_q16 = 22'd0;
        endcase
    endfunction
endpackage

// ===== rtl/atp_fir_cell.sv =====
`timescale 1ns / 1ps
// One tap of the three-axis delay line. On shift, it takes its left
// neighbor's sample; on accumulate, it adds coef * held sample to the
// partial sum passed in from the left and hands it on.
module atp_fir_cell
    import atp_pkg::*;
#(
    parameter int SW = 16,
    parameter logic [15:0] COEF = 16'd0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic [1:0]           axis,
    input  logic signed [SW-1:0] s_in,
    output logic signed [SW-1:0] s_out,
    input  logic signed [SW+19:0] acc_in,
    output logic signed [SW+19:0] acc_out
);
    logic signed [SW-1:0] x_reg, y_reg, z_reg;
    logic signed [SW-1:0] sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (shift)
        begin
            case (axis)
                2'd0: x_reg <= s_in;
                2'd1: y_reg <= s_in;
                default: z_reg <= s_in;
            endcase
        end
    end

    always_comb
    begin
        case (axis)
            2'd0: sel = x_reg;
            2'd1: sel = y_reg;
            default: sel = z_reg;
        endcase
    end

    assign s_out = sel;
    assign acc_out = acc_in + (SW+20)'($signed({1'b0, COEF}) * sel);
endmodule

// ===== rtl/atp_cordic.sv =====
`timescale 1ns / 1ps
// Iterative vectoring CORDIC, one micro-rotation per cycle.
module atp_cordic
    import atp_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] num,
    input  logic signed [15:0] den,
    output logic               done,
    output logic signed [15:0] angle
);
    localparam int NSTEP = (STEPS < 24) ? STEPS : 24;
    logic signed [39:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [4:0] i_reg;
    logic busy_reg, done_reg;
    logic signed [15:0] angle_reg;
    logic signed [39:0] dx, dy;
    logic signed [31:0] zr;
    logic signed [22:0] rr;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign zr = (z_reg + 32'sd256) >>> 9;
    assign rr = zr[22:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                i_reg <= '0;
                if (num == 16'sd0)
                begin
                    angle_reg <= (den < 0) ? ANGLE_MAX : 16'sd0;
                    done_reg <= 1'b1;
                end
                else if (den == 16'sd0)
                begin
                    angle_reg <= (num > 0) ? ANGLE_QTR : -ANGLE_QTR;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    if (den < 0)
                    begin
                        x_reg <= -({{4{den[15]}}, den, 20'd0});
                        y_reg <= -({{4{num[15]}}, num, 20'd0});
                        z_reg <= (num > 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
                    end
                    else
                    begin
                        x_reg <= {{4{den[15]}}, den, 20'd0};
                        y_reg <= {{4{num[15]}}, num, 20'd0};
                        z_reg <= '0;
                    end
                end
            end
            else if (busy_reg)
            begin
                if (i_reg == 5'(NSTEP))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (zr > 32'sd23040)
                        angle_reg <= ANGLE_MAX;
                    else if (zr < -32'sd23040)
                        angle_reg <= -ANGLE_MAX;
                    else
                        angle_reg <= rr[15:0];
                end
                else
                begin
                    i_reg <= i_reg + 5'd1;
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + $signed({10'd0, atan_q16(i_reg)});
                    end
                    else if (y_reg < 0)
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - $signed({10'd0, atan_q16(i_reg)});
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign angle = angle_reg;
endmodule

// ===== rtl/accel_tilt_pipeline_unit.sv =====
`timescale 1ns / 1ps
// Accelerometer tilt unit.
// s_axis carries one x,y,z sample in mg; m_axis returns the calibrated
// axes and the pitch and roll angles for it, one result item per sample.
// cfg writes the six calibration registers by index; unknown indexes are
// dropped. Write configuration only while the unit is idle.
// Each result item is built in order by the FIR row (one axis per cycle),
// the nine 3x3 products on the one shared multiplier (operand register,
// then accumulate), and the pitch and then roll angle on one iterative
// CORDIC. An angle that is a special case skips the CORDIC iterations.
// The unit accepts a new sample in the cycle after the previous result
// has been taken, and not before; while the receiver stalls, the unit
// holds m_axis_tvalid and the data, and the next sample waits.
// Reset clears the FIR history to zero and loads the default calibration.
module accel_tilt_pipeline_unit
    import atp_pkg::*;
#(
    parameter int TAPS = 5,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_x, sample_y, sample_z, each 16 bits from the lowest bit up
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cal_x, cal_y, cal_z, pitch_deg, roll_deg, 16 bits each, lowest first
    output logic [79:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = SW + 20;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIR  = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_P    = 3'd3;
    localparam logic [2:0] ST_R    = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [1:0] axis_reg;
    logic [3:0] mac_reg;
    cal_regs_t regs_reg;
    logic [47:0] in_reg;
    logic signed [AW-1:0] f_reg [3];
    logic signed [63:0] s_reg;
    logic signed [15:0] c_reg [3];
    logic signed [15:0] pitch_reg, roll_reg;
    logic signed [AW-1:0] prod_a_reg;
    logic signed [15:0] prod_b_reg;
    logic prod_v_reg;

    logic signed [SW-1:0] chain [TAPS+1];
    logic signed [AW-1:0] acc [TAPS+1];
    logic shift;
    logic signed [SW-1:0] cur;

    always_comb
    begin
        case (axis_reg)
            2'd0: cur = in_reg[SW-1:0];
            2'd1: cur = in_reg[16+SW-1:16];
            default: cur = in_reg[32+SW-1:32];
        endcase
    end

    assign shift = (state_reg == ST_FIR);
    assign chain[0] = cur;
    assign acc[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TAPS; g++)
        begin : g_tap
            if (g == 0)
            begin : g_new
                assign chain[1] = chain[0];
                assign acc[1] = acc[0] + AW'($signed({1'b0, fir_coef(0)}) * chain[0]);
            end
            else
            begin : g_cell
                atp_fir_cell #(.SW(SW), .COEF(fir_coef(g))) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift), .axis(axis_reg),
                    .s_in(chain[g]), .s_out(chain[g+1]),
                    .acc_in(acc[g]), .acc_out(acc[g+1]));
            end
        end
    endgenerate

    // Multiplier operand selection: row = mac/3, column = mac%3 (small table).
    logic [1:0] row, col;
    logic signed [15:0] coef_sel;
    always_comb
    begin
        case (mac_reg)
            4'd0: begin row = 2'd0; col = 2'd0; end
            4'd1: begin row = 2'd0; col = 2'd1; end
            4'd2: begin row = 2'd0; col = 2'd2; end
            4'd3: begin row = 2'd1; col = 2'd0; end
            4'd4: begin row = 2'd1; col = 2'd1; end
            4'd5: begin row = 2'd1; col = 2'd2; end
            4'd6: begin row = 2'd2; col = 2'd0; end
            4'd7: begin row = 2'd2; col = 2'd1; end
            default: begin row = 2'd2; col = 2'd2; end
        endcase
        case ({row, col})
            4'b0000: coef_sel = regs_reg.gain_x;
            4'b0001: coef_sel = CX_FROM_Y;
            4'b0010: coef_sel = CX_FROM_Z;
            4'b0100: coef_sel = CY_FROM_X;
            4'b0101: coef_sel = regs_reg.gain_y;
            4'b0110: coef_sel = CY_FROM_Z;
            4'b1000: coef_sel = CZ_FROM_X;
            4'b1001: coef_sel = CZ_FROM_Y;
            default: coef_sel = regs_reg.gain_z;
        endcase
    end

    logic signed [15:0] off_sel;
    always_comb
    begin
        case (row)
            2'd0: off_sel = regs_reg.offset_x;
            2'd1: off_sel = regs_reg.offset_y;
            default: off_sel = regs_reg.offset_z;
        endcase
    end

    logic signed [AW+15:0] prod_n;
    logic signed [63:0] prod, s_sum, rnd;
    logic signed [63:0] off64;
    assign prod_n = prod_a_reg * prod_b_reg;
    assign prod = 64'(prod_n);
    assign s_sum = s_reg + prod;
    assign rnd = (s_sum + 64'sd134217728) >>> 28;

    logic signed [15:0] sat;
    always_comb
    begin
        if (rnd > 64'sd32767) sat = 16'sh7fff;
        else if (rnd < -64'sd32768) sat = 16'sh8000;
        else sat = rnd[15:0];
    end
    assign off64 = 64'(off_sel) <<< 24;

    logic cd_start, cd_done;
    logic signed [15:0] cd_num, cd_angle;
    assign cd_num = (state_reg == ST_R) ? c_reg[1] : c_reg[0];
    atp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cd_start), .num(cd_num),
        .den(c_reg[2]), .done(cd_done), .angle(cd_angle));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign m_axis_tdata = {roll_reg, pitch_reg, c_reg[2], c_reg[1], c_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg <= '0;
            mac_reg <= '0;
            prod_v_reg <= 1'b0;
            cd_start <= 1'b0;
            regs_reg <= {16'sd16359, 16'sd16781, 16'sd16163,
                         16'sd141, 16'sd106, -16'sd861};
        end
        else
        begin
            cd_start <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_X: regs_reg.gain_x <= cfg_data;
                    REG_GAIN_Y: regs_reg.gain_y <= cfg_data;
                    REG_GAIN_Z: regs_reg.gain_z <= cfg_data;
                    REG_OFFSET_X: regs_reg.offset_x <= cfg_data;
                    REG_OFFSET_Y: regs_reg.offset_y <= cfg_data;
                    REG_OFFSET_Z: regs_reg.offset_z <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        in_reg <= s_axis_tdata;
                        axis_reg <= '0;
                        state_reg <= ST_FIR;
                    end
                end
                ST_FIR:
                begin
                    f_reg[axis_reg] <= acc[TAPS];
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg <= '0;
                        mac_reg <= '0;
                        prod_v_reg <= 1'b0;
                        state_reg <= ST_MAC;
                    end
                    else
                        axis_reg <= axis_reg + 2'd1;
                end
                ST_MAC:
                begin
                    // Register the operands first, then accumulate the product in the cycle after.
                    if (!prod_v_reg)
                    begin
                        prod_a_reg <= f_reg[col];
                        prod_b_reg <= coef_sel;
                        if (col == 2'd0)
                            s_reg <= off64;
                        prod_v_reg <= 1'b1;
                    end
                    else
                    begin
                        prod_v_reg <= 1'b0;
                        if (col == 2'd2)
                        begin
                            c_reg[row] <= sat;
                        end
                        else
                            s_reg <= s_sum;
                        if (mac_reg == 4'd8)
                        begin
                            state_reg <= ST_P;
                            cd_start <= 1'b1;
                        end
                        else
                            mac_reg <= mac_reg + 4'd1;
                    end
                end
                ST_P:
                begin
                    if (cd_done)
                    begin
                        pitch_reg <= cd_angle;
                        state_reg <= ST_R;
                        cd_start <= 1'b1;
                    end
                end
                ST_R:
                begin
                    if (cd_done && !cd_start)
                    begin
                        roll_reg <= cd_angle;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/accel_tilt_pipeline_unit_tb.sv =====
`timescale 1ns / 1ps
module accel_tilt_pipeline_unit_tb;
    import atp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] cz;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } tilt_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    sample_t pending_samples[$];
    tilt_t   expected_tilts[$];
    cal_regs_t cal;
    longint  axis_hist[3][4];
    int      errors;
    int      idle_cycles;
    int      send_gap;
    int      take_gap;
    bit      s_fire;
    bit      hold_send;
    bit      sink_calm;

    accel_tilt_pipeline_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] calibrate_axis(longint a, longint b, longint c,
        longint ga, longint gb, longint gc, longint off);
        longint s;
        s = a * ga + b * gb + c * gc + off * 64'sd16777216;
        s = floor_shift(s + 64'sd134217728, 28);
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s[15:0];
    endfunction

    function automatic longint atan_step(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic logic signed [15:0] cordic_angle(longint num, longint den);
        longint vx, vy, ang, dx, dy, r;
        if (num == 0)
            return (den < 0) ? ANGLE_MAX : 16'sd0;
        if (den == 0)
            return (num > 0) ? ANGLE_QTR : -ANGLE_QTR;
        vx = den * 1048576;
        vy = num * 1048576;
        ang = 0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            ang = (num > 0) ? longint'(HALF_TURN_Q16) : -longint'(HALF_TURN_Q16);
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx += dx;
                vy -= dy;
                ang += atan_step(i);
            end
            else if (vy < 0)
            begin
                vx -= dx;
                vy += dy;
                ang -= atan_step(i);
            end
        end
        r = floor_shift(ang + 256, 9);
        if (r > 23040)
            r = 23040;
        if (r < -23040)
            r = -23040;
        return r[15:0];
    endfunction

    function automatic tilt_t predict_tilt(sample_t smp);
        longint cur[3];
        longint filt[3];
        longint coef[5] = '{6554, 9830, 32768, 9830, 6554};
        tilt_t t;
        cur[0] = smp.x;
        cur[1] = smp.y;
        cur[2] = smp.z;
        for (int a = 0; a < 3; a++)
        begin
            filt[a] = coef[0] * cur[a];
            for (int k = 1; k < 5; k++)
                filt[a] += coef[k] * axis_hist[a][k - 1];
            for (int k = 3; k > 0; k--)
                axis_hist[a][k] = axis_hist[a][k - 1];
            axis_hist[a][0] = cur[a];
        end
        t.cx = calibrate_axis(filt[0], filt[1], filt[2], cal.gain_x, CX_FROM_Y, CX_FROM_Z,
            cal.offset_x);
        t.cy = calibrate_axis(filt[0], filt[1], filt[2], CY_FROM_X, cal.gain_y, CY_FROM_Z,
            cal.offset_y);
        t.cz = calibrate_axis(filt[0], filt[1], filt[2], CZ_FROM_X, CZ_FROM_Y, cal.gain_z,
            cal.offset_z);
        t.pitch = cordic_angle(t.cx, t.cz);
        t.roll = cordic_angle(t.cy, t.cz);
        return t;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 4000)) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    // Sample driver: an item accepted at the last rising edge is retired here.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap = 0;
        end
        else if (!s_axis_tvalid || s_fire)
        begin
            if (s_fire)
                void'(pending_samples.pop_front());
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0 && !hold_send)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_samples[0];
                send_gap = pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        s_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (s_fire)
            expected_tilts.push_back(predict_tilt(sample_t'(s_axis_tdata)));
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_gap = 0;
        end
        else if (sink_calm)
            m_axis_tready <= 1'b1;
        else if (take_gap > 0)
        begin
            take_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            take_gap = pick_gap();
        end
    end

    // Result monitor and watchdog.
    always @(posedge clk)
    begin
        tilt_t got;
        tilt_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("accel_tilt_pipeline_unit: mismatch");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = tilt_t'(m_axis_tdata);
                if (expected_tilts.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    want = expected_tilts.pop_front();
                    if (got.cx !== want.cx)
                        $display("%0t: cal_x expected %0d actual %0d", $time, want.cx, got.cx);
                    if (got.cy !== want.cy)
                        $display("%0t: cal_y expected %0d actual %0d", $time, want.cy, got.cy);
                    if (got.cz !== want.cz)
                        $display("%0t: cal_z expected %0d actual %0d", $time, want.cz, got.cz);
                    if (got.pitch !== want.pitch)
                        $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                            got.pitch);
                    if (got.roll !== want.roll)
                        $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                            got.roll);
                    if (got !== want)
                        errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_tilts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GAIN_X:   cal.gain_x = val;
            REG_GAIN_Y:   cal.gain_y = val;
            REG_GAIN_Z:   cal.gain_z = val;
            REG_OFFSET_X: cal.offset_x = val;
            REG_OFFSET_Y: cal.offset_y = val;
            REG_OFFSET_Z: cal.offset_z = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int n, bit tame);
        sample_t s;
        for (int i = 0; i < n; i++)
        begin
            if (tame)
            begin
                s.x = 16'(int'($urandom_range(0, 2400)) - 1200);
                s.y = 16'(int'($urandom_range(0, 2400)) - 1200);
                s.z = 16'(int'($urandom_range(0, 2400)) - 1200);
            end
            else
            begin
                s.x = rand_field();
                s.y = rand_field();
                s.z = rand_field();
            end
            pending_samples.push_back(s);
        end
    endtask

    initial
    begin
        logic [15:0] vals[6];
        errors = 0;
        idle_cycles = 0;
        hold_send = 0;
        sink_calm = 0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cal.gain_x = 16359;
        cal.gain_y = 16781;
        cal.gain_z = 16163;
        cal.offset_x = 141;
        cal.offset_y = 106;
        cal.offset_z = -861;
        for (int a = 0; a < 3; a++)
            for (int k = 0; k < 4; k++)
                axis_hist[a][k] = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero vector, both-zero angles, axis signs, full-scale inputs.
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd1000, 16'sd0, 16'sd0});
        pending_samples.push_back('{-16'sd1000, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd0, 16'sd1000, 16'sd0});
        pending_samples.push_back('{16'sd0, -16'sd1000, -16'sd1000});
        pending_samples.push_back('{-16'sd1000, 16'sd1000, 16'sd1000});
        pending_samples.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_samples.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_samples.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff});
        pending_samples.push_back('{16'sh8000, 16'sh7fff, -16'sd1});
        pending_samples.push_back('{16'shaaaa, 16'sh5555, 16'sh5555});
        pending_samples.push_back('{16'sh5555, 16'shaaaa, 16'shaaaa});
        wait_drained();

        // Zero gains and offsets leave only the fixed cross-axis terms in the atan arguments.
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(3'(r), 16'h0000);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hffff);
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_samples.push_back('{16'sd5, 16'sd0, 16'sd0});
        wait_drained();
        // Set the x and z offsets with the gains still zero, then send one zero sample.
        write_reg(REG_OFFSET_X, 16'sd4000);
        write_reg(REG_OFFSET_Z, -16'sd4000);
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0});
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: vals = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
                1: vals = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
                2: vals = '{16'd16359, 16'd16781, 16'd16163, 16'd141, 16'd106, 16'hfca3};
                default:
                    foreach (vals[r])
                        vals[r] = rand_field();
            endcase
            for (int r = 0; r < NUM_REGS; r++)
                write_reg(3'(r), vals[r]);
            sink_calm = (phase == 3);
            queue_random(RANDOM_ITEMS / 12, 1'b1);
            queue_random(RANDOM_ITEMS / 12, 1'b0);
            // Once half the items are sent, hold the sender until every result is back, then resume.
            while (pending_samples.size() > RANDOM_ITEMS / 12)
                @(posedge clk);
            hold_send = 1;
            while (expected_tilts.size() > 0 || s_axis_tvalid)
                @(posedge clk);
            hold_send = 0;
            wait_drained();
            sink_calm = 0;
        end
        if (errors == 0)
            $display("accel_tilt_pipeline_unit: match");
        else
            $display("accel_tilt_pipeline_unit: mismatch");
        $finish;
    end
endmodule
